FILE: rtl/clut_pkg.sv
// Shared types and codes for the palette texture expander.
`default_nettype none

package clut_pkg;

    localparam int PaletteDepth = 256;
    localparam int PalAddrW     = $clog2(PaletteDepth);
    localparam int QueueDepth   = 4;
    localparam int QueuePtrW    = $clog2(QueueDepth);
    localparam int CfgIndexW    = 1;
    localparam int CfgDataW     = 2;

    // Input command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TEXEL = 1'b1;

    // depth_mode codes
    localparam logic [1:0] MODE_4BIT  = 2'd0;
    localparam logic [1:0] MODE_8BIT  = 2'd1;
    localparam logic [1:0] MODE_BLACK = 2'd2;

    // Configuration register indexes
    localparam logic [CfgIndexW-1:0] REG_DEPTH_MODE = 1'b0;
    localparam logic [CfgIndexW-1:0] REG_TRANSP     = 1'b1;

    localparam logic [7:0] ALPHA_CLEAR  = 8'd0;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [7:0] ALPHA_SEMI   = 8'(255 / 4);

    typedef struct packed {
        logic        cmd;
        logic [7:0]  palette_index;
        logic [15:0] palette_word;
        logic [7:0]  texel_byte;
    } texel_word_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } pixel_word_t;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_PIX4,
        OP_PIX8,
        OP_FILL
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [7:0]  index;
        logic [15:0] word;
    } op_t;

endpackage

`default_nettype wire

FILE: rtl/clut_front.sv
// Front end: accepts input words, classifies them into ops and queues all but mode-3 texels.
`default_nettype none

module clut_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [1:0]             depth_mode,
    input  wire logic                   texel_valid,
    output logic                        texel_stall,
    input  wire clut_pkg::texel_word_t  texel_word,
    output logic                        op_valid,
    output clut_pkg::op_t               op,
    input  wire logic                   op_pop
);

    clut_pkg::op_t                      q_reg [clut_pkg::QueueDepth];
    logic [clut_pkg::QueuePtrW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [clut_pkg::QueuePtrW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [clut_pkg::QueuePtrW:0]       count_reg, count_next;
    logic                               accept;
    logic                               push;
    clut_pkg::op_t                      entry;

    assign texel_stall = (count_reg == (clut_pkg::QueuePtrW+1)'(clut_pkg::QueueDepth));
    assign accept      = texel_valid && !texel_stall;
    assign op_valid    = (count_reg != '0);
    assign op          = q_reg[rd_ptr_reg];

    // Classify: mode 3 texels are taken and dropped
    always_comb
    begin
        push        = 1'b0;
        entry.kind  = clut_pkg::OP_WRITE;
        entry.index = texel_word.palette_index;
        entry.word  = texel_word.palette_word;
        if (accept)
        begin
            if (texel_word.cmd == clut_pkg::CMD_WRITE)
            begin
                push = 1'b1;
            end
            else
            begin
                entry.index = texel_word.texel_byte;
                case (depth_mode)
                    clut_pkg::MODE_4BIT:
                    begin
                        push       = 1'b1;
                        entry.kind = clut_pkg::OP_PIX4;
                    end
                    clut_pkg::MODE_8BIT:
                    begin
                        push       = 1'b1;
                        entry.kind = clut_pkg::OP_PIX8;
                    end
                    clut_pkg::MODE_BLACK:
                    begin
                        push       = 1'b1;
                        entry.kind = clut_pkg::OP_FILL;
                    end
                    default:
                    begin
                        push = 1'b0;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = op_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !op_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && op_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/clut_back.sv
// Back end: palette memory, lookup sequencer and pixel expansion.
`default_nettype none

module clut_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   transparency_enable,
    input  wire logic                   op_valid,
    input  wire clut_pkg::op_t          op,
    output logic                        op_pop,
    output logic                        pixel_valid,
    input  wire logic                   pixel_stall,
    output clut_pkg::pixel_word_t       pixel_word
);

    // floor(c * 255 / 31)
    localparam logic [7:0] SCALE5 [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

    logic [15:0]                    pal_store_reg [clut_pkg::PaletteDepth];
    logic                           phase_reg, phase_next;
    logic                           s1_valid_reg, s1_valid_next;
    logic                           s1_last_reg, s1_fill_reg, s1_zero_reg;
    logic [15:0]                    rd_word_reg;
    logic                           pix_valid_reg, pix_valid_next;
    clut_pkg::pixel_word_t          pix_word_reg;

    logic                           out_free, s1_free, s1_move;
    logic                           issue, mem_we;
    logic [7:0]                     rd_idx;
    logic                           iss_last, iss_fill, iss_zero;
    logic [15:0]                    word;
    logic                           stp, black;
    clut_pkg::pixel_word_t          pix;

    assign out_free = !pix_valid_reg || !pixel_stall;
    assign s1_free  = !s1_valid_reg || out_free;
    assign s1_move  = s1_valid_reg && out_free;
    assign iss_zero = !({1'b0, rd_idx} < 9'(clut_pkg::PaletteDepth));

    // Sequencer over the queue head; 4-bit ops take two lookups, low nibble first
    always_comb
    begin
        issue      = 1'b0;
        op_pop     = 1'b0;
        mem_we     = 1'b0;
        phase_next = phase_reg;
        rd_idx     = op.index;
        iss_last   = 1'b1;
        iss_fill   = 1'b0;
        if (op_valid)
        begin
            case (op.kind)
                clut_pkg::OP_WRITE:
                begin
                    op_pop = 1'b1;
                    mem_we = ({1'b0, op.index} < 9'(clut_pkg::PaletteDepth));
                end
                clut_pkg::OP_PIX4:
                begin
                    rd_idx   = phase_reg ? {4'b0, op.index[7:4]} : {4'b0, op.index[3:0]};
                    iss_last = phase_reg;
                    if (s1_free)
                    begin
                        issue      = 1'b1;
                        op_pop     = phase_reg;
                        phase_next = !phase_reg;
                    end
                end
                clut_pkg::OP_PIX8:
                begin
                    if (s1_free)
                    begin
                        issue  = 1'b1;
                        op_pop = 1'b1;
                    end
                end
                clut_pkg::OP_FILL:
                begin
                    iss_fill = 1'b1;
                    if (s1_free)
                    begin
                        issue  = 1'b1;
                        op_pop = 1'b1;
                    end
                end
                default:
                begin
                    op_pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pal_store_reg[op.index[clut_pkg::PalAddrW-1:0]] <= op.word;
        end
        if (issue)
        begin
            rd_word_reg <= pal_store_reg[rd_idx[clut_pkg::PalAddrW-1:0]];
            s1_last_reg <= iss_last;
            s1_fill_reg <= iss_fill;
            s1_zero_reg <= iss_zero;
        end
    end

    // Expansion: 5->8 bit scale and alpha rules; fill ops give opaque white
    always_comb
    begin
        word  = s1_zero_reg ? 16'd0 : rd_word_reg;
        stp   = word[15];
        black = (word[14:0] == 15'd0);
        pix.red   = SCALE5[word[4:0]];
        pix.green = SCALE5[word[9:5]];
        pix.blue  = SCALE5[word[14:10]];
        pix.last  = s1_last_reg;
        if (!stp && black)
        begin
            pix.alpha = clut_pkg::ALPHA_CLEAR;
        end
        else if (transparency_enable && stp && !black)
        begin
            pix.alpha = clut_pkg::ALPHA_SEMI;
        end
        else
        begin
            pix.alpha = clut_pkg::ALPHA_OPAQUE;
        end
        if (s1_fill_reg)
        begin
            pix.red   = 8'd255;
            pix.green = 8'd255;
            pix.blue  = 8'd255;
            pix.alpha = clut_pkg::ALPHA_OPAQUE;
            pix.last  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            pix_word_reg <= pix;
        end
    end

    assign s1_valid_next  = issue || (s1_valid_reg && !out_free);
    assign pix_valid_next = s1_move || (pix_valid_reg && pixel_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            s1_valid_reg  <= 1'b0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            s1_valid_reg  <= s1_valid_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    assign pixel_valid = pix_valid_reg;
    assign pixel_word  = pix_word_reg;

endmodule

`default_nettype wire

FILE: rtl/clut_texel_to_rgba_expander_top.sv
// Top level of the palette texture expander: config registers, front and back.
//
// Usage:
//   texel channel (texel_valid / texel_stall / texel_word): each word either writes one
//   16-bit palette entry (cmd = write) or brings one texel byte to decode.
//   pixel channel (pixel_valid / pixel_stall / pixel_word): RGBA pixels, last set on
//   the final pixel of each texel byte. Palette writes and mode-3 texels give no word.
//   Config port (cfg_we / cfg_index / cfg_data): depth_mode and transparency_enable;
//   write only while the block is idle.
// Path: an accepted texel word passes the op queue, the lookup stage register and
//   the pixel output register. Throughput: 8-bit and black modes one texel per cycle
//   while pixel_stall stays low; 4-bit mode needs two lookups per texel, set by the
//   single read port of the palette memory (one lookup/cycle). Writes need no lookup.
// Reset: control state cleared, depth_mode = 8-bit, transparency on. Palette
//   contents are undefined until written; there is no clearing pass.
// Stall: the pixel output register holds under pixel_stall; the lookup stage and
//   the 4-entry op queue back up, and texel_stall rises when the queue is full.
`default_nettype none

module clut_texel_to_rgba_expander_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [clut_pkg::CfgIndexW-1:0]     cfg_index,
    input  wire logic [clut_pkg::CfgDataW-1:0]      cfg_data,
    input  wire logic                               texel_valid,
    output logic                                    texel_stall,
    input  wire clut_pkg::texel_word_t              texel_word,
    output logic                                    pixel_valid,
    input  wire logic                               pixel_stall,
    output clut_pkg::pixel_word_t                   pixel_word
);

    logic [1:0]         depth_mode_reg, depth_mode_next;
    logic               transp_reg, transp_next;
    logic               op_valid;
    logic               op_pop;
    clut_pkg::op_t      op;

    always_comb
    begin
        depth_mode_next = depth_mode_reg;
        transp_next     = transp_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                clut_pkg::REG_DEPTH_MODE: depth_mode_next = cfg_data;
                clut_pkg::REG_TRANSP:     transp_next     = cfg_data[0];
                default:                  depth_mode_next = depth_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_mode_reg <= clut_pkg::MODE_8BIT;
            transp_reg     <= 1'b1;
        end
        else
        begin
            depth_mode_reg <= depth_mode_next;
            transp_reg     <= transp_next;
        end
    end

    // Accept and classify; ops wait in a small queue
    clut_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .depth_mode  (depth_mode_reg),
        .texel_valid (texel_valid),
        .texel_stall (texel_stall),
        .texel_word  (texel_word),
        .op_valid    (op_valid),
        .op          (op),
        .op_pop      (op_pop)
    );

    // Palette lookup and RGBA expansion
    clut_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .transparency_enable (transp_reg),
        .op_valid            (op_valid),
        .op                  (op),
        .op_pop              (op_pop),
        .pixel_valid         (pixel_valid),
        .pixel_stall         (pixel_stall),
        .pixel_word          (pixel_word)
    );

    // Back end never pops an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        op_pop |-> op_valid)
        else $error("op popped from empty queue");

    // Input stalls only on a full, hence nonempty, queue
    a_stall_queue: assert property (@(posedge clk) disable iff (!rst_n)
        texel_stall |-> op_valid)
        else $error("texel_stall with empty queue");

    // Second nibble pixel is ready right behind the first
    a_pair_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && !pixel_stall && !pixel_word.last) |=>
            (pixel_valid && pixel_word.last))
        else $error("second pixel of a 4-bit texel missing");

endmodule

`default_nettype wire

FILE: tb/clut_pixel_checker.sv
`timescale 1ns / 100ps
// Pixel checker: shadows the palette and config, predicts pixels, compares.

module clut_pixel_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [clut_pkg::CfgIndexW-1:0]      cfg_index,
    input  logic [clut_pkg::CfgDataW-1:0]       cfg_data,
    input  logic                                texel_valid,
    input  logic                                texel_stall,
    input  clut_pkg::texel_word_t               texel_word,
    input  logic                                pixel_valid,
    input  logic                                pixel_stall,
    input  clut_pkg::pixel_word_t               pixel_word,
    output int unsigned                         mismatches,
    output int unsigned                         outstanding
);

    logic [15:0]           palette_copy [clut_pkg::PaletteDepth];
    logic [1:0]            depth_sel;
    logic                  transp_on;
    clut_pkg::pixel_word_t expected_pixels [$];

    initial mismatches = 0;

    // 5-bit channel to 8 bits, truncating c*255/31
    function automatic logic [7:0] widen5(logic [4:0] c);
        return 8'((int'(c) * 255) / 31);
    endfunction

    function automatic clut_pkg::pixel_word_t expand_entry(logic [15:0] entry, logic transp,
                                                           logic last_flag);
        clut_pkg::pixel_word_t px;
        logic                  stp;
        logic                  dark;
        px.red   = widen5(entry[4:0]);
        px.green = widen5(entry[9:5]);
        px.blue  = widen5(entry[14:10]);
        stp      = entry[15];
        dark     = (entry[14:0] == 15'd0);
        if (!stp && dark)
            px.alpha = clut_pkg::ALPHA_CLEAR;
        else if (transp && stp && !dark)
            px.alpha = clut_pkg::ALPHA_SEMI;
        else
            px.alpha = clut_pkg::ALPHA_OPAQUE;
        px.last = last_flag;
        return px;
    endfunction

    // append one predicted pixel at the tail
    task automatic expect_pixel(clut_pkg::pixel_word_t px);
        expected_pixels.insert(expected_pixels.size(), px);
    endtask

    task automatic report_field(string name, logic [7:0] want, logic [7:0] got);
        $display("%0t: pixel %s mismatch, expected %0d, got %0d", $time, name, want, got);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        clut_pkg::pixel_word_t want;
        if (!rst_n)
        begin
            depth_sel = clut_pkg::MODE_8BIT;
            transp_on = 1'b1;
            expected_pixels.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == clut_pkg::REG_DEPTH_MODE)
                    depth_sel = cfg_data;
                else if (cfg_index == clut_pkg::REG_TRANSP)
                    transp_on = cfg_data[0];
            end

            if (pixel_valid && !pixel_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: unexpected pixel word %h, expected none", $time,
                             pixel_word);
                    mismatches++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel_word.red !== want.red)
                        report_field("red", want.red, pixel_word.red);
                    if (pixel_word.green !== want.green)
                        report_field("green", want.green, pixel_word.green);
                    if (pixel_word.blue !== want.blue)
                        report_field("blue", want.blue, pixel_word.blue);
                    if (pixel_word.alpha !== want.alpha)
                        report_field("alpha", want.alpha, pixel_word.alpha);
                    if (pixel_word.last !== want.last)
                        report_field("last", 8'(want.last), 8'(pixel_word.last));
                end
            end

            if (texel_valid && !texel_stall)
            begin
                if (texel_word.cmd == clut_pkg::CMD_WRITE)
                    palette_copy[texel_word.palette_index] = texel_word.palette_word;
                else
                begin
                    case (depth_sel)
                        clut_pkg::MODE_4BIT:
                        begin
                            expect_pixel(expand_entry(
                                palette_copy[texel_word.texel_byte[3:0]], transp_on, 1'b0));
                            expect_pixel(expand_entry(
                                palette_copy[texel_word.texel_byte[7:4]], transp_on, 1'b1));
                        end
                        clut_pkg::MODE_8BIT:
                            expect_pixel(expand_entry(
                                palette_copy[texel_word.texel_byte], transp_on, 1'b1));
                        clut_pkg::MODE_BLACK:
                        begin
                            want.red   = 8'hff;
                            want.green = 8'hff;
                            want.blue  = 8'hff;
                            want.alpha = clut_pkg::ALPHA_OPAQUE;
                            want.last  = 1'b1;
                            expect_pixel(want);
                        end
                        default: ;  // mode three: no pixel
                    endcase
                end
            end

            outstanding = expected_pixels.size();
        end
    end

endmodule

FILE: tb/clut_texel_to_rgba_expander_top_test.sv
`timescale 1ns / 100ps
// Testbench top for the palette texture expander: stimulus, stalls, watchdog, verdict.

module clut_texel_to_rgba_expander_top_test;

    localparam int PhaseCount   = 12;
    localparam int PhaseWords   = 150;
    localparam int IdleLimit    = 4000;   // cycles with no word moving on either side
    localparam int SettleCycles = 8;      // covers the queue, lookup and output registers with margin

    // depth_mode value with no package name: texels make no pixels
    localparam logic [1:0] MODE_NONE = 2'd3;

    // receiver stall patterns
    localparam int STALL_NONE  = 0;
    localparam int STALL_SOLID = 1;
    localparam int STALL_RAND  = 2;

    logic                           clk         = 1'b0;
    logic                           rst_n       = 1'b0;
    logic                           cfg_we      = 1'b0;
    logic [clut_pkg::CfgIndexW-1:0] cfg_index   = '0;
    logic [clut_pkg::CfgDataW-1:0]  cfg_data    = '0;
    logic                           texel_valid = 1'b0;
    clut_pkg::texel_word_t          texel_word  = '0;
    logic                           pixel_stall = 1'b0;
    logic                           texel_stall;
    logic                           pixel_valid;
    clut_pkg::pixel_word_t          pixel_word;

    int unsigned mismatches;
    int unsigned outstanding;

    // registered at the rising edge, read by the driver at the falling edge
    logic        texel_taken;
    int unsigned quiet_cycles;

    // stimulus-side bookkeeping: which palette entries hold data, current mode
    bit          written [clut_pkg::PaletteDepth];
    logic [1:0]  cur_mode = clut_pkg::MODE_8BIT;
    int unsigned burst_left = 0;

    int unsigned stall_left = 0;
    int unsigned stall_kind = STALL_NONE;

    clut_texel_to_rgba_expander_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .texel_valid (texel_valid),
        .texel_stall (texel_stall),
        .texel_word  (texel_word),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_word  (pixel_word)
    );

    clut_pixel_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .texel_valid (texel_valid),
        .texel_stall (texel_stall),
        .texel_word  (texel_word),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_word  (pixel_word),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Acceptance flag for the driver, plus the watchdog. The watchdog restarts
    // whenever a word moves on either channel; long config settles and the
    // worst stall/gap stretches stay far below the limit.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            texel_taken  <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            texel_taken <= texel_valid && !texel_stall;
            if ((texel_valid && !texel_stall) || (pixel_valid && !pixel_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= IdleLimit)
            begin
                $display("clut_texel_to_rgba_expander_top_test: errors");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: free-running stretches, solid stalls and random chatter, so
    // backpressure lands on both pixels of a 4-bit texel and on the queue-full point.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_kind = $urandom_range(STALL_NONE, STALL_RAND);
            stall_left = (stall_kind == STALL_SOLID) ? $urandom_range(1, 15)
                                                     : $urandom_range(10, 60);
        end
        stall_left = stall_left - 1;
        case (stall_kind)
            STALL_NONE:  pixel_stall <= 1'b0;
            STALL_SOLID: pixel_stall <= 1'b1;
            default:     pixel_stall <= 1'($urandom_range(0, 1));
        endcase
    end

    // Sender: bursts of random length with random gaps in between. Called at a
    // falling edge; returns at the falling edge after the word was taken, so
    // valid is assigned exactly once per edge and held across stalls.
    task automatic send_word(clut_pkg::texel_word_t w);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                texel_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left  = burst_left - 1;
        texel_valid <= 1'b1;
        texel_word  <= w;
        do
            @(negedge clk);
        while (!texel_taken);
    endtask

    // unused fields carry random junk; the block must ignore them
    task automatic put_entry(logic [7:0] idx, logic [15:0] entry);
        clut_pkg::texel_word_t w;
        w.cmd           = clut_pkg::CMD_WRITE;
        w.palette_index = idx;
        w.palette_word  = entry;
        w.texel_byte    = 8'($urandom);
        written[idx]    = 1'b1;
        send_word(w);
    endtask

    task automatic put_texel(logic [7:0] b);
        clut_pkg::texel_word_t w;
        w.cmd           = clut_pkg::CMD_TEXEL;
        w.palette_index = 8'($urandom);
        w.palette_word  = 16'($urandom);
        w.texel_byte    = b;
        send_word(w);
    endtask

    // Hold the sender until every predicted pixel has come out. Always moves
    // on to a later falling edge, so valid is never driven twice in one step.
    task automatic drain();
        texel_valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
    endtask

    // Config only while idle; palette writes and mode-three texels leave no
    // trace in the checker, so wait out the pipeline after the drain.
    task automatic set_config(logic [1:0] mode, logic transp);
        drain();
        repeat (SettleCycles) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= clut_pkg::REG_DEPTH_MODE;
        cfg_data  <= mode;
        @(negedge clk);
        cfg_index <= clut_pkg::REG_TRANSP;
        cfg_data  <= {1'b0, transp};
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_mode  = mode;
    endtask

    // Palette words weighted toward the alpha corner cases: black with and
    // without the stp bit, full white, and plain random.
    function automatic logic [15:0] rand_entry();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'h8000;
            2:       return {1'($urandom_range(0, 1)), 15'h7fff};
            default: return 16'($urandom);
        endcase
    endfunction

    // Never look up an entry that was not written. Entries 0..15 are loaded
    // up front, so any byte is safe in 4-bit mode; in 8-bit mode an unwritten
    // index folds down to a low one.
    function automatic logic [7:0] pick_texel();
        logic [7:0] b;
        b = 8'($urandom);
        if (cur_mode == clut_pkg::MODE_8BIT && !written[b])
            b = b & 8'h0f;
        return b;
    endfunction

    initial
    begin
        int unsigned pick;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: load the low 16 entries with corner words (black, black+stp,
        // white, single channels, lsb-only, stp set and clear)
        put_entry(8'd0,  16'h0000);
        put_entry(8'd1,  16'h8000);
        put_entry(8'd2,  16'h7fff);
        put_entry(8'd3,  16'hffff);
        put_entry(8'd4,  16'h001f);
        put_entry(8'd5,  16'h03e0);
        put_entry(8'd6,  16'h7c00);
        put_entry(8'd7,  16'h801f);
        put_entry(8'd8,  16'h0001);
        put_entry(8'd9,  16'h8001);
        put_entry(8'd10, 16'h0421);
        put_entry(8'd11, 16'h5555);
        put_entry(8'd12, 16'haaaa);
        put_entry(8'd13, 16'h7ffe);
        put_entry(8'd14, 16'h8400);
        put_entry(8'd15, 16'h3def);

        // reset config: 8-bit, semi-transparency rules; all four alpha classes
        put_texel(8'h00);
        put_texel(8'h01);
        put_texel(8'h02);
        put_texel(8'h03);
        put_texel(8'h0f);

        // 4-bit, opaque rules: nibble order and extreme nibbles
        set_config(clut_pkg::MODE_4BIT, 1'b0);
        put_texel(8'h10);
        put_texel(8'h32);
        put_texel(8'hf0);

        // black mode fills opaque white and ignores the palette entirely
        set_config(clut_pkg::MODE_BLACK, 1'b1);
        put_texel(8'hff);

        // mode three swallows texels
        set_config(MODE_NONE, 1'b1);
        put_texel(8'ha5);

        // Random phases, each under its own setting; the first two pin the
        // mode extremes. Mid-phase the sender waits for the pipe to empty.
        for (int p = 0; p < PhaseCount; p++)
        begin
            if (p == 0)
                set_config(clut_pkg::MODE_4BIT, 1'b0);
            else if (p == 1)
                set_config(clut_pkg::MODE_BLACK, 1'b1);
            else
            begin
                pick = $urandom_range(0, 7);
                set_config((pick < 7) ? 2'(pick % 3) : MODE_NONE, 1'($urandom_range(0, 1)));
            end
            for (int k = 0; k < PhaseWords; k++)
            begin
                if (k == PhaseWords / 2)
                    drain();
                if ($urandom_range(0, 9) < 3)
                    put_entry(8'($urandom_range(0, 255)), rand_entry());
                else
                    put_texel(pick_texel());
            end
        end

        drain();
        repeat (SettleCycles) @(negedge clk);
        if (mismatches == 0)
            $display("clut_texel_to_rgba_expander_top_test: clean");
        else
            $display("clut_texel_to_rgba_expander_top_test: errors");
        $finish;
    end

endmodule
